// ----- hdl/pcebp_pkg.sv -----
// ----------------------------------------------------------------------------
// Prefix-code encoder package
// Shared constants and types for the table-driven encoder and bit packer.
// ----------------------------------------------------------------------------
package pcebp_pkg;

	localparam int SYM_W            = 8;
	localparam int LEN_W            = 6;
	localparam int BYTE_W           = 8;
	localparam int MODE_W           = 2;
	localparam int CODE_W_MAX       = 32;
	localparam int TABLE_DEPTH      = 256;
	localparam int QUEUE_DEPTH      = 2;
	localparam int MAX_CODE_LEN_DEF = 32;

	localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ENCODE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FINISH = 2'd2;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ----- hdl/pcebp_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pcebp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wen,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     ren,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wen) begin
			mem_q[waddr] <= wdata;
		end
		if (ren) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hdl/pcebp_front.sv -----
// ----------------------------------------------------------------------------
// Encoder front end
// Accepts words, writes table entries and looks up codes for the queue.
// ----------------------------------------------------------------------------
module pcebp_front #(
	parameter int MAX_CODE_LEN = pcebp_pkg::MAX_CODE_LEN_DEF,
	parameter int CODE_W = (MAX_CODE_LEN < pcebp_pkg::CODE_W_MAX) ? MAX_CODE_LEN
		: pcebp_pkg::CODE_W_MAX,
	parameter int ENTRY_W = CODE_W + pcebp_pkg::LEN_W + 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [pcebp_pkg::MODE_W-1:0]   mode,
	input  logic [pcebp_pkg::SYM_W-1:0]    symbol,
	input  logic [pcebp_pkg::CODE_W_MAX-1:0] code_bits,
	input  logic [pcebp_pkg::LEN_W-1:0]    code_length,
	input  pcebp_pkg::q_stat_t             q_stat,
	output logic                           push,
	output logic [ENTRY_W-1:0]             push_data
);

	import pcebp_pkg::*;

	localparam int RAM_W = CODE_W + LEN_W;

	logic                   accept;
	logic                   load_wen;
	logic                   lookup_ren;
	logic [LEN_W-1:0]       sat_len;
	logic [RAM_W-1:0]       ram_rdata;
	logic [TABLE_DEPTH-1:0] tbl_valid_q;
	logic                   valid_s1;
	logic                   fin_s1;
	logic                   hit_s1;

	assign in_ready   = !valid_s1 || !q_stat.full;
	assign accept     = in_valid && in_ready;
	assign load_wen   = accept && (mode == MODE_LOAD);
	assign lookup_ren = accept && (mode == MODE_ENCODE);
	assign sat_len    = (code_length > LEN_W'(CODE_W)) ? LEN_W'(CODE_W) : code_length;

	pcebp_ram #(
		.WIDTH(RAM_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.wen  (load_wen),
		.waddr(symbol),
		.wdata({sat_len, code_bits[CODE_W-1:0]}),
		.ren  (lookup_ren),
		.raddr(symbol),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_valid_q <= '0;
		end else if (load_wen) begin
			tbl_valid_q[symbol] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fin_s1   <= 1'b0;
			hit_s1   <= 1'b0;
		end else if (accept && ((mode == MODE_ENCODE) || (mode == MODE_FINISH))) begin
			valid_s1 <= 1'b1;
			fin_s1   <= (mode == MODE_FINISH);
			hit_s1   <= tbl_valid_q[symbol];
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	assign push      = valid_s1 && !q_stat.full;
	assign push_data = (hit_s1 && !fin_s1) ? {1'b0, ram_rdata} : {fin_s1, {RAM_W{1'b0}}};

endmodule

// ----- hdl/pcebp_queue.sv -----
// ----------------------------------------------------------------------------
// Decoupling queue
// Short FIFO between the front end and the bit packer.
// ----------------------------------------------------------------------------
module pcebp_queue #(
	parameter int WIDTH = 39,
	parameter int DEPTH = pcebp_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [WIDTH-1:0]   push_data,
	input  logic               pop,
	output logic [WIDTH-1:0]   pop_data,
	output pcebp_pkg::q_stat_t q_stat
);

	import pcebp_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign q_stat.full  = (count_q == CNT_W'(DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign pop_data     = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop && !q_stat.empty) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count lost a push");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !q_stat.empty)
		else $error("pop from empty queue");

endmodule

// ----- hdl/pcebp_back.sv -----
// ----------------------------------------------------------------------------
// Bit packer
// Appends codes LSB first to the pending bits and emits full and flushed bytes.
// ----------------------------------------------------------------------------
module pcebp_back #(
	parameter int MAX_CODE_LEN = pcebp_pkg::MAX_CODE_LEN_DEF,
	parameter int CODE_W = (MAX_CODE_LEN < pcebp_pkg::CODE_W_MAX) ? MAX_CODE_LEN
		: pcebp_pkg::CODE_W_MAX,
	parameter int ENTRY_W = CODE_W + pcebp_pkg::LEN_W + 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pcebp_pkg::q_stat_t           q_stat,
	input  logic [ENTRY_W-1:0]           pop_data,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [pcebp_pkg::BYTE_W-1:0] packed_byte,
	output logic                         last_of_run,
	output logic                         is_flush
);

	import pcebp_pkg::*;

	localparam int ACC_W = CODE_W + BYTE_W - 1;
	localparam int CNT_W = $clog2(ACC_W + 1);
	localparam logic [CNT_W:0] ONE_BYTE  = (CNT_W + 1)'(BYTE_W);
	localparam logic [CNT_W:0] TWO_BYTES = (CNT_W + 1)'(2 * BYTE_W);

	logic              ent_fin;
	logic [LEN_W-1:0]  ent_len;
	logic [CODE_W-1:0] ent_code;
	logic [ACC_W-1:0]  acc_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_free;
	logic              have_byte;
	logic              emit_full;
	logic              emit_flush;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;
	logic              out_flush_q;

	assign ent_fin  = pop_data[ENTRY_W-1];
	assign ent_len  = pop_data[CODE_W +: LEN_W];
	assign ent_code = pop_data[CODE_W-1:0] & ~({CODE_W{1'b1}} << ent_len);

	assign out_free   = !out_valid_q || out_ready;
	assign have_byte  = ({1'b0, cnt_q} >= ONE_BYTE);
	assign emit_full  = have_byte && out_free;
	assign pop        = !q_stat.empty && !have_byte && (!ent_fin || out_free);
	assign emit_flush = pop && ent_fin && (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (emit_full) begin
			acc_q <= acc_q >> BYTE_W;
			cnt_q <= cnt_q - CNT_W'(BYTE_W);
		end else if (pop && ent_fin) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (pop) begin
			acc_q <= acc_q | (ACC_W'(ent_code) << cnt_q[2:0]);
			cnt_q <= cnt_q + CNT_W'(ent_len);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_full || emit_flush) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_full || emit_flush) begin
			out_byte_q  <= acc_q[BYTE_W-1:0];
			out_last_q  <= emit_flush || ({1'b0, cnt_q} < TWO_BYTES);
			out_flush_q <= emit_flush;
		end
	end

	assign out_valid   = out_valid_q;
	assign packed_byte = out_byte_q;
	assign last_of_run = out_last_q;
	assign is_flush    = out_flush_q;

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CNT_W'(ACC_W))
		else $error("pending bit count beyond accumulator");
	assert property (@(posedge clk) disable iff (!arst_n) (acc_q >> cnt_q) == '0)
		else $error("accumulator holds bits above the count");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_flush_q) |-> out_last_q)
		else $error("flushed word not marked last");
	assert property (@(posedge clk) disable iff (!arst_n)
		emit_flush |=> (cnt_q == '0))
		else $error("flush left pending bits");

endmodule

// ----- hdl/prefix_code_encoder_bit_packer.sv -----
// ----------------------------------------------------------------------------
// Prefix-code encoder with bit packer
// Top level: table-driven code lookup feeding an LSB-first byte packer.
// ----------------------------------------------------------------------------
// The slave channel takes one word per item. s_tuser carries the mode: load
// writes one 256-entry code table entry, encode looks up a symbol and appends
// its code bits, finish emits the pending partial byte padded with zeros.
// The master channel returns packed bytes; m_tlast marks the final byte that
// one input item causes and m_tuser marks a flushed partial byte.
// A load writes its table entry when accepted. An encode or finish is
// registered in the table read stage, then enters a two-entry queue. The
// packer takes one queue entry per cycle while fewer than eight bits are
// pending (a finish also waits for a free output register), then emits one
// byte per cycle while the receiver accepts. The byte emit loop sets the rate.
// Reset clears the table (through one valid bit per entry), the pending bits
// and the queue. On a receiver stall the output register holds its word, the
// packer and queue fill, and s_tready falls once queue and read stage are full.
// ----------------------------------------------------------------------------
module prefix_code_encoder_bit_packer #(
	parameter int MAX_CODE_LEN = pcebp_pkg::MAX_CODE_LEN_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [47:0]                  s_tdata,  // symbol, code_bits, code_length
	input  logic [pcebp_pkg::MODE_W-1:0] s_tuser,  // mode
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [pcebp_pkg::BYTE_W-1:0] m_tdata,  // packed_byte
	output logic                         m_tlast,
	output logic                         m_tuser   // is_flush
);

	import pcebp_pkg::*;

	localparam int CODE_W  = (MAX_CODE_LEN < CODE_W_MAX) ? MAX_CODE_LEN : CODE_W_MAX;
	localparam int ENTRY_W = CODE_W + LEN_W + 1;

	q_stat_t              q_stat;
	logic                 push;
	logic [ENTRY_W-1:0]   push_data;
	logic                 pop;
	logic [ENTRY_W-1:0]   pop_data;

	pcebp_front #(
		.MAX_CODE_LEN(MAX_CODE_LEN),
		.CODE_W      (CODE_W),
		.ENTRY_W     (ENTRY_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.mode       (s_tuser),
		.symbol     (s_tdata[7:0]),
		.code_bits  (s_tdata[39:8]),
		.code_length(s_tdata[45:40]),
		.q_stat     (q_stat),
		.push       (push),
		.push_data  (push_data)
	);

	pcebp_queue #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.q_stat   (q_stat)
	);

	pcebp_back #(
		.MAX_CODE_LEN(MAX_CODE_LEN),
		.CODE_W      (CODE_W),
		.ENTRY_W     (ENTRY_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.pop_data   (pop_data),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.packed_byte(m_tdata),
		.last_of_run(m_tlast),
		.is_flush   (m_tuser)
	);

endmodule
